// ===== rtl/pvs_pkg.sv =====
// Shared types, constants and tables of the polyphonic voice synth core.
package pvs_pkg;

    localparam int VOICES_DEF  = 16;
    localparam int SAMPLE_RATE = 48000;

    localparam int KEY_W   = 7;
    localparam int VEL_W   = 7;
    localparam int TICKS_W = 16;
    localparam int SPT_W   = 24;
    localparam int STEP_W  = 16;
    localparam int SMP_W   = 16;
    localparam int PHASE_W = 24;
    localparam int ENV_W   = 17;
    localparam int REM_W   = 32;
    localparam int SUM_W   = 24;

    localparam logic [STEP_W-1:0] ATTACK_RST  = 16'd273;
    localparam logic [STEP_W-1:0] RELEASE_RST = 16'd17;
    localparam logic [STEP_W-1:0] COEF_RST    = 16'd31477;
    localparam logic [SPT_W-1:0]  SPT_RST     = 24'd64000;

    localparam logic [1:0] FUNC_RENDER  = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON = 2'd1;
    localparam logic [1:0] FUNC_ALL_OFF = 2'd2;

    localparam logic [1:0] CFG_ATTACK  = 2'd0;
    localparam logic [1:0] CFG_RELEASE = 2'd1;
    localparam logic [1:0] CFG_COEF    = 2'd2;
    localparam logic [1:0] CFG_SPT     = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OFF, ST_NO_SCAN, ST_NO_ERD, ST_NO_ECMP, ST_NO_WR,
        ST_R_RD, ST_R_LD, ST_R_ENV, ST_R_T2, ST_R_IN1, ST_R_IN2, ST_R_Y,
        ST_R_MIXA, ST_R_MIX, ST_R_FILT, ST_R_P1, ST_R_P2, ST_R_DIVA,
        ST_R_DIVQ, ST_R_ACC, ST_CLIP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_CLEAR_ALL, OP_SCAN, OP_RD, OP_ECMP, OP_NOTE_WR,
        OP_LOAD, OP_ENV, OP_T2, OP_IN1, OP_IN2, OP_Y, OP_MIXA, OP_MIX,
        OP_FILT, OP_P1, OP_P2, OP_DIVA, OP_DIVQ, OP_ACC, OP_CLIP
    } dp_op_t;

    typedef struct packed {
        logic active;
        logic retire;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic [PHASE_W-1:0]      inc;
        logic [ENV_W-1:0]        env;
        logic signed [SMP_W-1:0] filt;
        logic [VEL_W-1:0]        vel;
        logic [REM_W-1:0]        rem;
    } voice_t;

    // Top octave (keys 120..131) in Hz, Q16.16.
    function automatic logic [31:0] top_hz(input logic [3:0] note);
        logic [31:0] hz;
        case (note)
            4'd0:    hz = 32'd548668578;
            4'd1:    hz = 32'd581294109;
            4'd2:    hz = 32'd615859655;
            4'd3:    hz = 32'd652480576;
            4'd4:    hz = 32'd691279090;
            4'd5:    hz = 32'd732384684;
            4'd6:    hz = 32'd775934543;
            4'd7:    hz = 32'd822074013;
            4'd8:    hz = 32'd870957077;
            4'd9:    hz = 32'd922746880;
            4'd10:   hz = 32'd977616265;
            4'd11:   hz = 32'd1035748353;
            default: hz = 32'd0;
        endcase
        return hz;
    endfunction

    function automatic logic [15:0] tanh_pt(input logic [5:0] i);
        logic [15:0] v;
        case (i)
            6'd0:  v = 16'd0;     6'd1:  v = 16'd4075;  6'd2:  v = 16'd8026;
            6'd3:  v = 16'd11743; 6'd4:  v = 16'd15143; 6'd5:  v = 16'd18173;
            6'd6:  v = 16'd20813; 6'd7:  v = 16'd23070; 6'd8:  v = 16'd24956;
            6'd9:  v = 16'd26519; 6'd10: v = 16'd27797; 6'd11: v = 16'd28831;
            6'd12: v = 16'd29660; 6'd13: v = 16'd30322; 6'd14: v = 16'd30847;
            6'd15: v = 16'd31262; 6'd16: v = 16'd31589; 6'd17: v = 16'd31846;
            6'd18: v = 16'd32048; 6'd19: v = 16'd32206; 6'd20: v = 16'd32329;
            6'd21: v = 16'd32426; 6'd22: v = 16'd32500; 6'd23: v = 16'd32559;
            6'd24: v = 16'd32606; 6'd25: v = 16'd32642; 6'd26: v = 16'd32670;
            6'd27: v = 16'd32691; 6'd28: v = 16'd32708; 6'd29: v = 16'd32722;
            6'd30: v = 16'd32732; 6'd31: v = 16'd32740; 6'd32: v = 16'd32746;
            default: v = 16'd32746;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/pvs_ram.sv =====
// Generic single-port-write RAM with registered read.
module pvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pvs_ctrl.sv =====
// Sequencer for note allocation, all-off and per-voice sample rendering.
module pvs_ctrl import pvs_pkg::*; #(
    parameter int VOICES = VOICES_DEF,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  dp_status_t    status,
    output dp_op_t        op,
    output logic [VW-1:0] idx
);

    localparam logic [VW-1:0] LAST = VW'(VOICES - 1);

    state_t        state_reg, state_next;
    logic [VW-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx      = idx_reg;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                begin
                    op = OP_LATCH;
                    case (func)
                        FUNC_RENDER:  state_next = ST_R_RD;
                        FUNC_NOTE_ON: state_next = ST_NO_SCAN;
                        FUNC_ALL_OFF: state_next = ST_OFF;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OFF:
            begin
                op         = OP_CLEAR_ALL;
                state_next = ST_IDLE;
            end
            // look for the first free voice
            ST_NO_SCAN:
            begin
                op = OP_SCAN;
                if (!status.active)
                begin
                    state_next = ST_NO_WR;
                end
                else if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_NO_ERD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // all busy: steal the lowest envelope
            ST_NO_ERD:
            begin
                op         = OP_RD;
                state_next = ST_NO_ECMP;
            end
            ST_NO_ECMP:
            begin
                op = OP_ECMP;
                if (idx_reg == LAST)
                begin
                    state_next = ST_NO_WR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_NO_ERD;
                end
            end
            ST_NO_WR:
            begin
                op         = OP_NOTE_WR;
                state_next = ST_IDLE;
            end
            ST_R_RD:
            begin
                op = OP_RD;
                if (status.active)
                begin
                    state_next = ST_R_LD;
                end
                else if (idx_reg == LAST)
                begin
                    state_next = ST_CLIP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_R_LD:
            begin
                op         = OP_LOAD;
                state_next = ST_R_ENV;
            end
            ST_R_ENV:
            begin
                op = OP_ENV;
                if (!status.retire)
                begin
                    state_next = ST_R_T2;
                end
                else if (idx_reg == LAST)
                begin
                    state_next = ST_CLIP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_R_RD;
                end
            end
            ST_R_T2:
            begin
                op         = OP_T2;
                state_next = ST_R_IN1;
            end
            ST_R_IN1:
            begin
                op         = OP_IN1;
                state_next = ST_R_IN2;
            end
            ST_R_IN2:
            begin
                op         = OP_IN2;
                state_next = ST_R_Y;
            end
            ST_R_Y:
            begin
                op         = OP_Y;
                state_next = ST_R_MIXA;
            end
            ST_R_MIXA:
            begin
                op         = OP_MIXA;
                state_next = ST_R_MIX;
            end
            ST_R_MIX:
            begin
                op         = OP_MIX;
                state_next = ST_R_FILT;
            end
            ST_R_FILT:
            begin
                op         = OP_FILT;
                state_next = ST_R_P1;
            end
            ST_R_P1:
            begin
                op         = OP_P1;
                state_next = ST_R_P2;
            end
            ST_R_P2:
            begin
                op         = OP_P2;
                state_next = ST_R_DIVA;
            end
            ST_R_DIVA:
            begin
                op         = OP_DIVA;
                state_next = ST_R_DIVQ;
            end
            ST_R_DIVQ:
            begin
                op         = OP_DIVQ;
                state_next = ST_R_ACC;
            end
            ST_R_ACC:
            begin
                op = OP_ACC;
                if (idx_reg == LAST)
                begin
                    state_next = ST_CLIP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_R_RD;
                end
            end
            // hold until the output register is free
            ST_CLIP:
            begin
                if (!status.out_busy)
                begin
                    op         = OP_CLIP;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pvs_dp.sv =====
// Datapath: config registers, voice flags, voice memory, oscillator, filter, mixer.
module pvs_dp import pvs_pkg::*; #(
    parameter int VOICES = VOICES_DEF,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [SPT_W-1:0]        cfg_data,
    input  logic [KEY_W-1:0]        note_key,
    input  logic [VEL_W-1:0]        note_velocity,
    input  logic [TICKS_W-1:0]      note_ticks,
    input  dp_op_t                  op,
    input  logic [VW-1:0]           idx,
    output dp_status_t              status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SMP_W-1:0] sample
);

    // phase increment per key
    logic [PHASE_W-1:0] inc_tab [128];

    for (genvar k = 0; k < 128; k++)
    begin : g_inc
        localparam logic [63:0] HZ  = 64'(top_hz(4'(k % 12)) >> (10 - k / 12));
        localparam logic [63:0] INC = (HZ * 64'd256 + 64'(SAMPLE_RATE / 2))
                                      / 64'(SAMPLE_RATE);
        assign inc_tab[k] = (INC > 64'hFFFFFF) ? 24'hFFFFFF : INC[PHASE_W-1:0];
    end

    logic [STEP_W-1:0] atk_reg, rel_reg, coef_reg;
    logic [SPT_W-1:0]  spt_reg;
    logic [VOICES-1:0] active_reg, releasing_reg;
    logic              out_valid_reg;

    logic [KEY_W-1:0]   key_reg;
    logic [VEL_W-1:0]   vel_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [REM_W-1:0]   len_reg;
    logic [VW-1:0]      victim_reg;
    logic [ENV_W-1:0]   best_env_reg;

    logic [PHASE_W-1:0]      w_phase, w_inc;
    logic [ENV_W-1:0]        w_env;
    logic signed [SMP_W-1:0] w_filt;
    logic [VEL_W-1:0]        w_vel;
    logic [REM_W-1:0]        w_rem;

    logic [16:0]             t_reg, t2_reg, in1_reg, in2_reg;
    logic signed [SMP_W-1:0] sine_reg;
    logic signed [33:0]      mixa_reg;
    logic signed [16:0]      s_reg;
    logic signed [33:0]      p1_reg;
    logic [20:0]             vg_reg;
    logic signed [55:0]      prod_reg;
    logic [22:0]             a_reg;
    logic [15:0]             q0_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SMP_W-1:0] sample_reg;

    voice_t        rd_voice, wr_voice;
    logic [119:0]  rd_bits;
    logic          ram_we;
    logic [VW-1:0] ram_waddr;

    pvs_ram #(
        .WIDTH($bits(voice_t)),
        .DEPTH(VOICES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_voice),
        .raddr(idx),
        .rdata(rd_bits)
    );

    assign rd_voice = voice_t'(rd_bits);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx;
        wr_voice  = '{phase: w_phase, inc: w_inc, env: w_env, filt: w_filt,
                      vel: w_vel, rem: w_rem};
        if (op == OP_NOTE_WR)
        begin
            ram_we    = 1'b1;
            ram_waddr = victim_reg;
            wr_voice  = '{phase: '0, inc: inc_tab[key_reg], env: '0, filt: '0,
                          vel: vel_reg, rem: (len_reg == '0) ? 32'd1 : len_reg};
        end
        else if (op == OP_P1)
        begin
            ram_we = 1'b1;
        end
    end

    // envelope step
    logic [17:0]        env_inc;
    logic [ENV_W-1:0]   env_up;
    logic               rel_end;

    assign env_inc = {1'b0, w_env} + {2'b0, atk_reg};
    assign env_up  = (env_inc > 18'd65536) ? 17'd65536 : env_inc[ENV_W-1:0];
    assign rel_end = releasing_reg[idx] && (w_env <= {1'b0, rel_reg});

    assign status.active   = active_reg[idx];
    assign status.retire   = (op == OP_ENV) && rel_end;
    assign status.out_busy = out_valid_reg;

    // oscillator, filter and gain arithmetic
    logic [16:0]             t_c;
    logic [33:0]             t_sq, m2, m3;
    logic [31:0]             m1;
    logic [16:0]             y_raw;
    logic [15:0]             y_cl;
    logic signed [SMP_W-1:0] saw;
    logic signed [33:0]      mix_sum;
    logic signed [17:0]      fdiff;
    logic signed [34:0]      coef_s, fprod;
    logic signed [33:0]      env_s;
    logic signed [55:0]      vg_s;
    logic [55:0]             mag;
    logic [43:0]             q0_full;
    logic [23:0]             rem_r;
    logic [15:0]             q_fix;

    assign t_c     = w_phase[22] ? (17'd65536 - {1'b0, w_phase[21:6]})
                                 : {1'b0, w_phase[21:6]};
    assign t_sq    = 34'(t_c) * 34'(t_c);
    assign m1      = 32'(t2_reg) * 32'd4640;
    assign m2      = 34'(t2_reg) * 34'(in1_reg);
    assign m3      = 34'(t_reg) * 34'(in2_reg);
    assign y_raw   = m3[33:17];
    assign y_cl    = (y_raw > 17'd32767) ? 16'd32767 : y_raw[15:0];
    assign saw     = {~w_phase[23], w_phase[22:8]};
    assign mix_sum = mixa_reg + 34'(sine_reg) * 34'sd26214;
    assign fdiff   = 18'(s_reg) - 18'(w_filt);
    assign coef_s  = {19'd0, coef_reg};
    assign fprod   = coef_s * 35'(fdiff);
    assign env_s   = {17'd0, w_env};
    assign vg_s    = {35'd0, vg_reg};
    assign mag     = prod_reg[55] ? 56'(-prod_reg) : 56'(prod_reg);
    assign q0_full = 44'(a_reg) * 44'd1056832;
    assign rem_r   = 24'(a_reg) - 24'(q0_reg) * 24'd127;
    assign q_fix   = (rem_r >= 24'd127) ? q0_reg + 16'd1 : q0_reg;

    // soft clip
    logic [SUM_W-1:0] smag;
    logic [11:0]      sidx;
    logic [15:0]      tlo, thi, tdiff, tout;
    logic [27:0]      tint;

    assign smag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign sidx  = smag[SUM_W-1:12];
    assign tlo   = tanh_pt({1'b0, sidx[4:0]});
    assign thi   = tanh_pt(6'({1'b0, sidx[4:0]}) + 6'd1);
    assign tdiff = thi - tlo;
    assign tint  = 28'(tdiff) * 28'(smag[11:0]);
    assign tout  = (sidx >= 12'd32) ? 16'd32746 : tlo + 16'(tint >> 12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_reg       <= ATTACK_RST;
            rel_reg       <= RELEASE_RST;
            coef_reg      <= COEF_RST;
            spt_reg       <= SPT_RST;
            active_reg    <= '0;
            releasing_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ATTACK:  atk_reg  <= cfg_data[STEP_W-1:0];
                    CFG_RELEASE: rel_reg  <= cfg_data[STEP_W-1:0];
                    CFG_COEF:    coef_reg <= cfg_data[STEP_W-1:0];
                    CFG_SPT:     spt_reg  <= cfg_data;
                    default:     atk_reg  <= atk_reg;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_CLEAR_ALL: active_reg <= '0;
                OP_NOTE_WR:
                begin
                    active_reg[victim_reg]    <= 1'b1;
                    releasing_reg[victim_reg] <= 1'b0;
                end
                OP_ENV:
                begin
                    if (rel_end)
                    begin
                        active_reg[idx] <= 1'b0;
                    end
                    else if (!releasing_reg[idx] && w_rem <= 32'd1)
                    begin
                        releasing_reg[idx] <= 1'b1;
                    end
                end
                OP_CLIP: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LATCH:
            begin
                key_reg   <= note_key;
                vel_reg   <= note_velocity;
                ticks_reg <= note_ticks;
                sum_reg   <= '0;
            end
            OP_SCAN:
            begin
                len_reg <= 32'((40'(ticks_reg) * 40'(spt_reg)) >> 8);
                if (!active_reg[idx])
                begin
                    victim_reg <= idx;
                end
            end
            OP_ECMP:
            begin
                if (idx == '0 || rd_voice.env < best_env_reg)
                begin
                    best_env_reg <= rd_voice.env;
                    victim_reg   <= idx;
                end
            end
            OP_LOAD:
            begin
                w_phase <= rd_voice.phase;
                w_inc   <= rd_voice.inc;
                w_env   <= rd_voice.env;
                w_filt  <= rd_voice.filt;
                w_vel   <= rd_voice.vel;
                w_rem   <= rd_voice.rem;
            end
            OP_ENV:
            begin
                if (releasing_reg[idx])
                begin
                    w_env <= w_env - {1'b0, rel_reg};
                end
                else
                begin
                    w_env <= env_up;
                    w_rem <= (w_rem <= 32'd1) ? 32'd0 : w_rem - 32'd1;
                end
                w_phase <= w_phase + w_inc;
            end
            OP_T2:
            begin
                t_reg  <= t_c;
                t2_reg <= t_sq[32:16];
            end
            OP_IN1: in1_reg <= 17'(32'd42047 - (m1 >> 16));
            OP_IN2: in2_reg <= 17'(34'd102944 - (m2 >> 16));
            OP_Y:   sine_reg <= w_phase[23] ? -$signed(y_cl) : $signed(y_cl);
            OP_MIXA: mixa_reg <= 34'(saw) * 34'sd39322;
            OP_MIX:  s_reg <= 17'(mix_sum >>> 16);
            OP_FILT: w_filt <= w_filt + 16'(fprod >>> 16);
            OP_P1:
            begin
                p1_reg <= 34'(w_filt) * env_s;
                vg_reg <= 21'(21'(w_vel) * 21'd13107);
            end
            OP_P2:   prod_reg <= 56'(p1_reg) * vg_s;
            OP_DIVA: a_reg <= mag[54:32];
            OP_DIVQ: q0_reg <= q0_full[42:27];
            OP_ACC:
            begin
                sum_reg <= prod_reg[55] ? sum_reg - SUM_W'(q_fix)
                                        : sum_reg + SUM_W'(q_fix);
            end
            OP_CLIP: sample_reg <= sum_reg[SUM_W-1] ? -$signed(tout) : $signed(tout);
            default: sum_reg <= sum_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

// ===== rtl/polyphonic_voice_synth_core.sv =====
// Top level of the polyphonic voice synth core.
//
//  channel   signals                                      role
//  in        in_valid/in_ready, func, note_key,           tick, note on, all off
//            note_velocity, note_ticks
//  out       out_valid/out_ready, sample                  one sample per tick
//  config    cfg_write, cfg_index, cfg_data               register writes
//
// A tick walks the voices one at a time through the voice memory: an idle voice is only
// read, one that ends its release is read, loaded and has its envelope stepped, and an
// active one goes on through the oscillator, filter, gain and accumulate steps.
// A note on scans the voices for the first free one and writes it there; when all are
// busy it reads every envelope and steals the voice with the lowest one.
// Reset clears the voice flags, no memory sweep.
// A finished sample waits in the output register; the next item is accepted
// meanwhile, and a tick holds before its final step until that register is free.
module polyphonic_voice_synth_core import pvs_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [SPT_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              func,
    input  logic [KEY_W-1:0]        note_key,
    input  logic [VEL_W-1:0]        note_velocity,
    input  logic [TICKS_W-1:0]      note_ticks,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SMP_W-1:0] sample
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    dp_op_t        op;
    logic [VW-1:0] idx;
    dp_status_t    status;

    pvs_ctrl #(
        .VOICES(VOICES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func    (func),
        .status  (status),
        .op      (op),
        .idx     (idx)
    );

    pvs_dp #(
        .VOICES(VOICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .note_key     (note_key),
        .note_velocity(note_velocity),
        .note_ticks   (note_ticks),
        .op           (op),
        .idx          (idx),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample)
    );

endmodule
